// ===== src/lcd_pkg.sv =====
`default_nettype none

package lcd_pkg;

    // Operation carried by an input transaction.
    typedef enum logic [1:0] {
        ACT_CHAR  = 2'd0,
        ACT_EMPTY = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } lcd_action_t;

    // Character codes that the scanner reacts to.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // One accepted input transaction as held in the input register.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic       first_of_line;
        logic       last_of_line;
    } lcd_item_t;

    // Single-bit scanner state kept across characters and lines.
    typedef struct packed {
        logic inside_string;
        logic escape_pending;
        logic defining_mode;
        logic double_equal_last;
        logic previous_was_equal;
        logic skip_rest_of_line;
        logic skip_answer;
    } lcd_flags_t;

endpackage

`default_nettype wire

// ===== src/lcd_item_if.sv =====
`default_nettype none

interface lcd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic       first_of_line;
    logic       last_of_line;

    modport source (
        output valid, action, char_code, first_of_line, last_of_line,
        input  ready
    );

    modport sink (
        input  valid, action, char_code, first_of_line, last_of_line,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/lcd_result_if.sv =====
`default_nettype none

interface lcd_result_if;
    logic valid;
    logic ready;
    logic continued;

    modport source (
        output valid, continued,
        input  ready
    );

    modport sink (
        input  valid, continued,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/lcd_in_reg.sv =====
`default_nettype none

module lcd_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lcd_item_if.sink               item,
    input  wire logic              advance,
    output logic                   held_valid,
    output lcd_pkg::lcd_item_t     held_item
);
    import lcd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lcd_item_t item_reg;

    // The register frees up whenever its content is consumed downstream.
    assign item.ready = !valid_reg || advance;
    assign valid_next = item.valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.action        <= item.action;
            item_reg.char_code     <= item.char_code;
            item_reg.first_of_line <= item.first_of_line;
            item_reg.last_of_line  <= item.last_of_line;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;
endmodule

`default_nettype wire

// ===== src/lcd_scan.sv =====
`default_nettype none

module lcd_scan #(
    parameter int DEPTH_WIDTH = 8
) (
    input  wire lcd_pkg::lcd_item_t         cur_item,
    input  wire logic signed [DEPTH_WIDTH-1:0] depth,
    input  wire lcd_pkg::lcd_flags_t        flags,
    output logic signed [DEPTH_WIDTH-1:0]   depth_next,
    output lcd_pkg::lcd_flags_t             flags_next,
    output logic                            has_result,
    output logic                            answer
);
    import lcd_pkg::*;

    localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
    localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};
    localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_ZERO = '0;

    always_comb
    begin
        logic signed [DEPTH_WIDTH-1:0] d;
        lcd_flags_t                    f;
        logic                          eq_now;
        logic [7:0]                    c;

        d          = depth;
        f          = flags;
        eq_now     = 1'b0;
        c          = cur_item.char_code;
        has_result = 1'b0;
        answer     = 1'b0;

        unique case (cur_item.action)
            ACT_QUERY:
            begin
                has_result = 1'b1;
                answer     = (d > DEPTH_ZERO);
            end
            ACT_EMPTY:
            begin
                f.skip_rest_of_line  = 1'b0;
                f.double_equal_last  = 1'b0;
                f.previous_was_equal = 1'b0;
                f.defining_mode      = 1'b0;
                has_result           = 1'b1;
                if (d < DEPTH_ZERO)
                begin
                    d      = DEPTH_ZERO;
                    answer = 1'b0;
                end
                else
                begin
                    answer = (d > DEPTH_ZERO) || f.inside_string;
                end
            end
            ACT_CHAR:
            begin
                if (cur_item.first_of_line)
                begin
                    f.skip_rest_of_line  = 1'b0;
                    f.double_equal_last  = 1'b0;
                    f.previous_was_equal = 1'b0;
                    if (c == CH_HASH && d == DEPTH_ZERO)
                    begin
                        f.skip_rest_of_line = 1'b1;
                        f.skip_answer       = 1'b0;
                    end
                    else if (c == CH_NL)
                    begin
                        f.skip_rest_of_line = 1'b1;
                        f.skip_answer       = 1'b1;
                    end
                    else if (c != CH_SPACE && c != CH_TAB)
                    begin
                        f.defining_mode = 1'b0;
                    end
                end

                if (!f.skip_rest_of_line)
                begin
                    if (f.escape_pending)
                    begin
                        f.escape_pending = 1'b0;
                    end
                    else if (f.inside_string)
                    begin
                        if (c == CH_UNDER)
                        begin
                            f.escape_pending = 1'b1;
                        end
                        else if (c == CH_QUOTE)
                        begin
                            f.inside_string = 1'b0;
                        end
                    end
                    else
                    begin
                        unique case (c)
                            CH_UNDER:
                            begin
                                f.escape_pending = 1'b1;
                            end
                            CH_QUOTE:
                            begin
                                f.inside_string     = 1'b1;
                                f.double_equal_last = 1'b0;
                            end
                            CH_LPAREN, CH_LBRACE:
                            begin
                                if (d != DEPTH_MAX)
                                begin
                                    d = d + 1'b1;
                                end
                            end
                            CH_RPAREN, CH_RBRACE:
                            begin
                                if (d != DEPTH_MIN)
                                begin
                                    d = d - 1'b1;
                                end
                            end
                            CH_EQUAL:
                            begin
                                if (f.previous_was_equal)
                                begin
                                    f.double_equal_last = 1'b1;
                                end
                                eq_now = 1'b1;
                            end
                            CH_SEMI, CH_SPACE, CH_NL:
                            begin
                            end
                            default:
                            begin
                                f.double_equal_last = 1'b0;
                            end
                        endcase
                    end
                    f.previous_was_equal = eq_now;
                end

                if (cur_item.last_of_line)
                begin
                    has_result = 1'b1;
                    if (f.skip_rest_of_line)
                    begin
                        f.skip_rest_of_line = 1'b0;
                        answer              = f.skip_answer;
                    end
                    else if (d < DEPTH_ZERO)
                    begin
                        d      = DEPTH_ZERO;
                        answer = 1'b0;
                    end
                    else
                    begin
                        if (f.double_equal_last)
                        begin
                            f.defining_mode = 1'b1;
                        end
                        answer = f.defining_mode || (d > DEPTH_ZERO) || f.inside_string;
                    end
                end
            end
            default:
            begin
                // Unused action: no state change, no result.
            end
        endcase

        depth_next = d;
        flags_next = f;
    end
endmodule

`default_nettype wire

// ===== src/line_continuation_detector.sv =====
`default_nettype none

// Line continuation detector.
//
// The item channel carries source text one character per transaction, with
// marks for the first and last character of a line, plus two commands: an
// empty line and a query of the open bracket count. The result channel
// returns one bit per line end, empty line or query, telling whether the
// line needs a continuation line (or, for a query, whether brackets are open).
// Characters that do not end a line produce no result transaction.
//
// Throughput is one transaction per cycle while the receiver keeps up: the
// input register, the scanner logic and the result register form a two-entry
// pipeline, so a new item is taken while a finished result still waits on the
// result channel. The scanner state (bracket depth, string, escape and
// defining flags) is updated in the same cycle the item leaves the input
// register.
//
// Reset clears the scanner state to zero and both pipeline registers to empty.
// When the receiver stalls, the result register holds its value, the input
// register fills, and then the item channel deasserts ready.
module line_continuation_detector #(
    parameter int DEPTH_WIDTH = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcd_item_if.sink    item,
    lcd_result_if.source result
);
    import lcd_pkg::*;

    logic                          held_valid;
    lcd_item_t                     held_item;
    logic                          advance;

    logic signed [DEPTH_WIDTH-1:0] depth_reg;
    logic signed [DEPTH_WIDTH-1:0] depth_next;
    lcd_flags_t                    flags_reg;
    lcd_flags_t                    flags_next;
    logic                          has_result;
    logic                          answer;

    logic                          out_valid_reg;
    logic                          out_bit_reg;
    logic                          consume;

    // The held item moves on whenever the result register is empty or is
    // being emptied in this cycle.
    assign advance = !out_valid_reg || result.ready;
    assign consume = held_valid && advance;

    lcd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    lcd_scan #(
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_scan (
        .cur_item   (held_item),
        .depth      (depth_reg),
        .flags      (flags_reg),
        .depth_next (depth_next),
        .flags_next (flags_next),
        .has_result (has_result),
        .answer     (answer)
    );

    // Scanner state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= consume && has_result;
            if (consume)
            begin
                depth_reg <= depth_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && has_result)
        begin
            out_bit_reg <= answer;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.continued = out_bit_reg;

    // A query never changes the bracket depth.
    a_query_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && held_item.action == ACT_QUERY) |=> depth_reg == $past(depth_reg))
        else $error("bracket depth changed on a query");

    // A new result only appears after an item was consumed.
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(consume))
        else $error("result appeared without a consumed item");

    // After a line end the skip flag is always cleared.
    a_skip_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && held_item.action == ACT_CHAR && held_item.last_of_line)
        |=> !flags_reg.skip_rest_of_line)
        else $error("skip flag left set after line end");

    // An empty line leaves defining mode off.
    a_empty_clears_def: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && held_item.action == ACT_EMPTY) |=> !flags_reg.defining_mode)
        else $error("defining mode set after empty line");
endmodule

`default_nettype wire

// ===== bench/lcd_scoreboard_pkg.sv =====
`timescale 1ns / 100ps

package lcd_scoreboard_pkg;

    import lcd_pkg::*;

    localparam int DEPTH_W = 8;
    localparam logic signed [DEPTH_W-1:0] DEPTH_TOP    = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic signed [DEPTH_W-1:0] DEPTH_BOTTOM = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic signed [DEPTH_W-1:0] DEPTH_ONE    = {{(DEPTH_W-1){1'b0}}, 1'b1};
    localparam int REPORT_LIMIT = 10;

    // Tracks the scanner state of the block and the line answers still owed.
    class lcd_scoreboard;

        logic signed [DEPTH_W-1:0] depth;
        bit in_string;
        bit escaped;
        bit defining;
        bit ends_double_eq;
        bit last_was_eq;
        bit line_fixed;
        bit fixed_answer;

        bit answers_owed[$];
        int answers_checked;
        int mismatches;
        bit hit_top;
        bit hit_bottom;

        function new();
            depth = '0;
            in_string = 0;
            escaped = 0;
            defining = 0;
            ends_double_eq = 0;
            last_was_eq = 0;
            line_fixed = 0;
            fixed_answer = 0;
            answers_checked = 0;
            mismatches = 0;
            hit_top = 0;
            hit_bottom = 0;
        endfunction

        // A negative depth at a line end is forgiven and answers no.
        function bit close_line();
            if (depth < 0)
            begin
                depth = '0;
                return 1'b0;
            end
            if (ends_double_eq)
                defining = 1'b1;
            return defining || (depth > 0) || in_string;
        endfunction

        function void scan_char(logic [7:0] code);
            bit eq_now;
            eq_now = 1'b0;
            if (escaped)
                escaped = 1'b0;
            else if (in_string)
            begin
                if (code == CH_UNDER)
                    escaped = 1'b1;
                else if (code == CH_QUOTE)
                    in_string = 1'b0;
            end
            else
            begin
                case (code)
                    CH_UNDER:
                        escaped = 1'b1;
                    CH_QUOTE:
                    begin
                        in_string = 1'b1;
                        ends_double_eq = 1'b0;
                    end
                    CH_LPAREN, CH_LBRACE:
                        if (depth != DEPTH_TOP)
                            depth = depth + DEPTH_ONE;
                        else
                            hit_top = 1'b1;
                    CH_RPAREN, CH_RBRACE:
                        if (depth != DEPTH_BOTTOM)
                            depth = depth - DEPTH_ONE;
                        else
                            hit_bottom = 1'b1;
                    CH_EQUAL:
                    begin
                        if (last_was_eq)
                            ends_double_eq = 1'b1;
                        eq_now = 1'b1;
                    end
                    CH_SEMI, CH_SPACE, CH_NL:
                        ;
                    default:
                        ends_double_eq = 1'b0;
                endcase
            end
            last_was_eq = eq_now;
        endfunction

        // Called for every accepted input transaction.
        function void note_item(lcd_action_t act, logic [7:0] code, bit first, bit last);
            case (act)
                ACT_QUERY:
                    answers_owed.push_back(depth > 0);
                ACT_EMPTY:
                begin
                    line_fixed = 1'b0;
                    ends_double_eq = 1'b0;
                    last_was_eq = 1'b0;
                    defining = 1'b0;
                    answers_owed.push_back(close_line());
                end
                ACT_CHAR:
                begin
                    if (first)
                    begin
                        line_fixed = 1'b0;
                        ends_double_eq = 1'b0;
                        last_was_eq = 1'b0;
                        if (code == CH_HASH && depth == 0)
                        begin
                            line_fixed = 1'b1;
                            fixed_answer = 1'b0;
                        end
                        else if (code == CH_NL)
                        begin
                            line_fixed = 1'b1;
                            fixed_answer = 1'b1;
                        end
                        else if (code != CH_SPACE && code != CH_TAB)
                            defining = 1'b0;
                    end
                    if (!line_fixed)
                        scan_char(code);
                    if (last)
                    begin
                        if (line_fixed)
                        begin
                            line_fixed = 1'b0;
                            answers_owed.push_back(fixed_answer);
                        end
                        else
                            answers_owed.push_back(close_line());
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] %s", $time, msg);
        endfunction

        // Called for every accepted result transaction.
        function void check_result(logic continued);
            bit want;
            answers_checked++;
            if (answers_owed.size() == 0)
            begin
                report($sformatf("answer %0d arrived with none owed (continued=%0b)",
                                 answers_checked, continued));
                return;
            end
            want = answers_owed.pop_front();
            if (continued !== want)
                report($sformatf("answer %0d: expected continued=%0b, got %0b",
                                 answers_checked, want, continued));
        endfunction

        function int owed();
            return answers_owed.size();
        endfunction

        function int failures();
            return mismatches + answers_owed.size();
        endfunction

    endclass

endpackage

// ===== bench/line_continuation_detector_test.sv =====
`timescale 1ns / 100ps

// Drives text into the line continuation detector one character per
// transaction and checks every answer against a scoreboard that tracks the
// scanner state. The run goes through three idle mixes on the two channels,
// a long result stall that backs the pipeline up into the item channel, and
// a pass that drives the bracket depth into both saturation limits.
module line_continuation_detector_test;

    import lcd_pkg::*;
    import lcd_scoreboard_pkg::*;

    typedef logic [7:0] text_t[$];

    // Cycles with no transaction on either channel before the run is abandoned.
    // The worst honest cases are the long receiver hold-off and runs of random
    // idling at 87 percent on either side, both far below this.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 60;
    // The block holds items only in its input and result registers, so this is plenty.
    localparam int DRAIN_CYCLES   = 10;
    localparam logic [7:0] CH_LETTER_A = 8'h61;
    localparam logic [7:0] CH_LETTER_X = 8'h78;
    localparam logic [7:0] CH_LETTER_Y = 8'h79;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lcd_item_if   item_ch();
    lcd_result_if result_ch();

    line_continuation_detector #(
        .DEPTH_WIDTH(DEPTH_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch)
    );

    lcd_scoreboard sb = new();

    // Idle percentages of the two sides, changed by the main sequence per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // The main sequence bumps hold_requests; the receiver notices the change
    // and then holds ready low for HOLD_CYCLES on its own count.
    int hold_requests = 0;
    int chars_sent = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    // Receiver: random backpressure, plus the occasional long hold-off.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Both channels are sampled at the clock edge, before any of this edge's
    // nonblocking updates land, so the monitor sees exactly what the block saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                sb.note_item(lcd_action_t'(item_ch.action), item_ch.char_code,
                             item_ch.first_of_line, item_ch.last_of_line);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.continued);
        end
    end

    // Watchdog: counts cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("line_continuation_detector_test NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, idling first at the current sender rate, and returns
    // at the edge where it is accepted. Valid stays high for the next call.
    task automatic send_item(input lcd_action_t act, input logic [7:0] code,
                             input bit first, input bit last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.action        <= act;
        item_ch.char_code     <= code;
        item_ch.first_of_line <= first;
        item_ch.last_of_line  <= last;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (act != ACT_NONE)
            chars_sent++;
    endtask

    // Sends a run of characters; the start and end marks can be left off.
    task automatic send_text(input text_t text, input bit mark_first = 1'b1,
                             input bit mark_last = 1'b1);
        for (int i = 0; i < text.size(); i++)
            send_item(ACT_CHAR, text[i], mark_first && (i == 0),
                      mark_last && (i == text.size() - 1));
    endtask

    function automatic text_t text_of(string s);
        text_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Character mix that favors the codes the scanner reacts to.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0:  return CH_HASH;
            1:  return CH_UNDER;
            2:  return CH_QUOTE;
            3:  return CH_LPAREN;
            4:  return CH_LBRACE;
            5:  return CH_RPAREN;
            6:  return CH_RBRACE;
            7:  return CH_EQUAL;
            8:  return CH_EQUAL;
            9:  return CH_SEMI;
            10: return CH_SPACE;
            11: return CH_NL;
            12: return CH_TAB;
            13: return CH_LETTER_A;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sender pause: nothing is offered until every owed answer has arrived.
    task automatic wait_for_answers();
        item_ch.valid <= 1'b0;
        while (sb.owed() != 0)
            @(posedge clk);
    endtask

    // Random traffic. Most of it is whole lines with random content, since
    // that is what reaches the defining and string logic; the rest is
    // commands, unused actions, lines with broken marks and raw noise.
    task automatic run_random(input int count);
        int stop_at;
        int kind;
        int len;
        text_t line;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                line = {};
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    line.push_back(pick_char());
                send_text(line);
            end
            else if (kind < 78)
                send_item(ACT_EMPTY, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (kind < 85)
                send_item(ACT_QUERY, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (kind < 89)
                send_item(ACT_NONE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (kind < 94)
            begin
                line = {};
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    line.push_back(pick_char());
                send_text(line, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
                send_item(lcd_action_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        text_t line;

        item_ch.valid         <= 1'b0;
        item_ch.action        <= ACT_CHAR;
        item_ch.char_code     <= '0;
        item_ch.first_of_line <= 1'b0;
        item_ch.last_of_line  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: sender idles rarely, receiver stalls most of the time.
        send_idle_pct = 11;
        recv_idle_pct = 87;

        // Directed lines. A query right out of reset sees no open brackets.
        send_item(ACT_QUERY, 8'h00, 1'b0, 1'b0);
        // A comment line at depth zero answers no and ignores the rest.
        send_text(text_of("#("));
        // A line that begins with a newline always asks for more.
        send_text(text_of("\n"));
        // A line ending in a double equal sign enters defining mode; a line
        // that starts with a space stays in it, one with a letter leaves it.
        send_text({CH_LETTER_A, CH_EQUAL, CH_EQUAL});
        send_text({CH_SPACE, CH_LETTER_X});
        send_text({CH_LETTER_Y});
        // Open brackets carry over lines, and a hash is no comment then.
        send_text(text_of("(("));
        send_item(ACT_QUERY, 8'hFF, 1'b1, 1'b1);
        send_text(text_of("#"));
        // Going below zero answers no and the depth starts over at zero.
        send_text(text_of(")))"));
        // An underscore escapes the quote, so the string stays open.
        send_text(text_of("\"_\""));
        send_text(text_of("\""));
        // An underscore outside a string escapes the bracket after it.
        send_text(text_of("_("));
        send_item(ACT_EMPTY, 8'h00, 1'b0, 1'b0);
        send_item(ACT_NONE, 8'hFF, 1'b1, 1'b1);
        send_text({8'h00});
        // No start mark: the characters just extend the previous line.
        send_item(ACT_CHAR, CH_LPAREN, 1'b0, 1'b0);
        send_item(ACT_CHAR, CH_RPAREN, 1'b0, 1'b1);

        run_random(215);
        wait_for_answers();

        // Phase two: the sender is the slow side.
        send_idle_pct = 87;
        recv_idle_pct = 11;
        run_random(215);
        wait_for_answers();

        // Phase three: no idling. The receiver holds off for a long stretch
        // first so the pipeline fills and the item channel drops ready.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        run_random(40);

        // Drive the depth into its upper limit over several lines, then
        // down through zero into the lower limit within a single line.
        line = {};
        repeat (10)
            line.push_back(CH_LBRACE);
        repeat (13)
            send_text(line);
        send_item(ACT_QUERY, 8'h00, 1'b0, 1'b0);
        line = {};
        repeat (260)
            line.push_back(CH_RPAREN);
        send_text(line);

        run_random(40);

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d characters and commands, %0d answers checked, over three idle mixes",
                 chars_sent, sb.answers_checked);
        $display("and a long result stall; depth limits hit: upper %0b, lower %0b.",
                 sb.hit_top, sb.hit_bottom);
        if (sb.failures() == 0)
            $display("line_continuation_detector_test OK");
        else
        begin
            $display("%0d mismatches, %0d answers never arrived", sb.mismatches, sb.owed());
            $display("line_continuation_detector_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lcd_pkg.sv
src/lcd_item_if.sv
src/lcd_result_if.sv
src/lcd_in_reg.sv
src/lcd_scan.sv
src/line_continuation_detector.sv
bench/lcd_scoreboard_pkg.sv
bench/line_continuation_detector_test.sv
